// ===== hdl/ppts_pkg.sv =====
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared types and constants for the preemptive priority tick scheduler.
// ----------------------------------------------------------------------------
package ppts_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int SLOT_BITS   = $clog2(NUM_SLOTS);
  localparam int COUNT_BITS  = $clog2(NUM_SLOTS + 1);
  localparam int PRIO_BITS   = 8;
  localparam int IDENT_BITS  = 8;
  localparam int ARRIVE_BITS = 16;
  localparam int BURST_BITS  = 16;
  localparam int TIME_BITS   = 24;

  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 56;
  localparam int OUT_USER_BITS = 3;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // tuser value on the input side
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic [IDENT_BITS-1:0]  ident;
    logic [PRIO_BITS-1:0]   prio;
    logic [ARRIVE_BITS-1:0] arrival;
    logic [BURST_BITS-1:0]  burst;
  } slot_info_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_LAST   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_REPORT = 5'b10000
  } sched_state_t;

endpackage

// ===== hdl/preemptive_priority_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_tick_scheduler
// Process table with a one-slot-per-cycle priority scan for each time tick.
// ----------------------------------------------------------------------------
// Input stream: tuser is the mode (0 load, 1 tick); tdata carries the process
// entry for a load. A load is written straight into the table in the cycle
// of its transfer and gives no result, and the block stays ready; a load on
// a full table is dropped. A tick walks the loaded slots through a single
// comparator, one slot per cycle from the table memory, then updates the
// chosen slot and builds the result. The scan, last-compare, update and
// report steps lie between the tick transfer and the output register; an
// empty table skips the scan and last-compare steps.
// The input is not ready while a tick is being worked on.
// The output register holds a result until it is taken; loads are still
// accepted meanwhile, and a following tick waits in its report step until
// the earlier result has gone.
// Reset clears time, counts, the sequencer and the output valid; the table
// memory is not cleared, as only slots below the load count are read.
// ----------------------------------------------------------------------------
module preemptive_priority_tick_scheduler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [7:0] proc_ident, [23:8] arrival_time, [39:24] burst_time,
  // [47:40] prio_level
  input  logic [ppts_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // [0] mode
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [7:0] running_ident, [31:8] turnaround, [55:32] wait_time
  output logic [ppts_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  // [0] idle, [1] finished, [2] all_done
  output logic [ppts_pkg::OUT_USER_BITS-1:0]   m_tuser
);
  import ppts_pkg::*;

  sched_state_t state;

  slot_info_t            info_mem [NUM_SLOTS];
  logic [BURST_BITS-1:0] rem_mem  [NUM_SLOTS];
  slot_info_t            info_q;
  logic [BURST_BITS-1:0] rem_q;

  logic [TIME_BITS-1:0]  cur_time;
  logic [COUNT_BITS-1:0] loaded_count;
  logic [COUNT_BITS-1:0] finished_count;

  logic [SLOT_BITS-1:0]  idx;
  logic [SLOT_BITS-1:0]  pend_idx;
  logic                  pend;

  logic                  best_valid;
  logic [SLOT_BITS-1:0]  best_idx;
  slot_info_t            best_info;
  logic [BURST_BITS-1:0] best_rem;

  logic                  fin;
  logic [TIME_BITS-1:0]  tat;

  logic                  in_xfer;
  logic                  do_load;
  logic                  eligible;
  logic                  better;
  logic [BURST_BITS-1:0] rem_new;
  logic [TIME_BITS-1:0]  time_next;
  logic [TIME_BITS-1:0]  wait_calc;
  logic                  out_free;

  logic                  rem_we;
  logic [SLOT_BITS-1:0]  rem_waddr;
  logic [BURST_BITS-1:0] rem_wdata;
  slot_info_t            load_info;

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign do_load  = in_xfer && (s_tuser == MODE_LOAD) &&
                    (loaded_count != COUNT_BITS'(NUM_SLOTS));
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    load_info.ident   = s_tdata[7:0];
    load_info.arrival = s_tdata[23:8];
    load_info.burst   = s_tdata[39:24];
    load_info.prio    = s_tdata[40 +: PRIO_BITS];
  end

  // comparator for the slot whose data has just come out of the table
  always_comb begin
    eligible = (rem_q != '0) && ({{(TIME_BITS-ARRIVE_BITS){1'b0}}, info_q.arrival} <= cur_time);
    better   = !best_valid || (info_q.prio < best_info.prio) ||
               ((info_q.prio == best_info.prio) && (info_q.arrival < best_info.arrival));
  end

  assign rem_new   = best_rem - BURST_BITS'(1);
  assign time_next = (cur_time == TIME_MAX) ? cur_time : cur_time + TIME_BITS'(1);
  assign wait_calc = (tat >= {{(TIME_BITS-BURST_BITS){1'b0}}, best_info.burst}) ?
                     tat - {{(TIME_BITS-BURST_BITS){1'b0}}, best_info.burst} : '0;

  always_comb begin
    rem_we    = 1'b0;
    rem_waddr = loaded_count[SLOT_BITS-1:0];
    rem_wdata = load_info.burst;
    if (do_load) begin
      rem_we = 1'b1;
    end else if (state == ST_UPDATE && best_valid) begin
      rem_we    = 1'b1;
      rem_waddr = best_idx;
      rem_wdata = rem_new;
    end
  end

  // table memory, registered read at the scan index
  always_ff @(posedge clk) begin
    if (do_load) begin
      info_mem[loaded_count[SLOT_BITS-1:0]] <= load_info;
    end
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    info_q <= info_mem[idx];
    rem_q  <= rem_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cur_time       <= '0;
      loaded_count   <= '0;
      finished_count <= '0;
      m_tvalid       <= 1'b0;
      pend           <= 1'b0;
      best_valid     <= 1'b0;
      idx            <= '0;
    end else begin
      // the report step drives the output valid itself
      if (m_tvalid && m_tready && state != ST_REPORT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (do_load) begin
            loaded_count <= loaded_count + COUNT_BITS'(1);
            if (load_info.burst == '0) begin
              finished_count <= finished_count + COUNT_BITS'(1);
            end
          end
          if (in_xfer && s_tuser == MODE_TICK) begin
            idx        <= '0;
            pend       <= 1'b0;
            best_valid <= 1'b0;
            state      <= (loaded_count == '0) ? ST_UPDATE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend     <= 1'b1;
          pend_idx <= idx;
          if (pend && eligible && better) begin
            best_valid <= 1'b1;
            best_idx   <= pend_idx;
            best_info  <= info_q;
            best_rem   <= rem_q;
          end
          if ({1'b0, idx} == loaded_count - COUNT_BITS'(1)) begin
            state <= ST_LAST;
          end else begin
            idx <= idx + SLOT_BITS'(1);
          end
        end
        ST_LAST: begin
          if (eligible && better) begin
            best_valid <= 1'b1;
            best_idx   <= pend_idx;
            best_info  <= info_q;
            best_rem   <= rem_q;
          end
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          cur_time <= time_next;
          fin      <= best_valid && (rem_new == '0);
          tat      <= time_next - {{(TIME_BITS-ARRIVE_BITS){1'b0}}, best_info.arrival};
          if (best_valid && rem_new == '0) begin
            finished_count <= finished_count + COUNT_BITS'(1);
          end
          state <= ST_REPORT;
        end
        ST_REPORT: begin
          if (out_free) begin
            m_tvalid      <= 1'b1;
            m_tdata[7:0]  <= best_valid ? best_info.ident : '0;
            m_tdata[31:8] <= fin ? tat : '0;
            m_tdata[55:32] <= fin ? wait_calc : '0;
            m_tuser[0]    <= !best_valid;
            m_tuser[1]    <= fin;
            m_tuser[2]    <= (finished_count == loaded_count);
            idx           <= '0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
